@@ hw/rtl/scalar_kalman_filter_defines.svh @@
// Assertion macros used by the scalar Kalman filter checker.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SKF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scalar_kalman_filter assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SKF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scalar_kalman_filter assertion failed");

`endif

@@ hw/rtl/skf_pkg.sv @@
// Types and constants shared by the scalar Kalman filter modules.
`default_nettype none

package skf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 17;
  localparam int unsigned DivSteps = 17;
  localparam int unsigned CntW = $clog2(DivSteps);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [GainW-1:0] GainOne = 17'd65536;

  localparam logic [DataW-1:0] ProcNoiseRst = 32'd6554;
  localparam logic [DataW-1:0] MeasNoiseRst = 32'd6554;
  localparam logic [DataW-1:0] InitEstRst = 32'd327680;
  localparam logic [DataW-1:0] InitCovRst = 32'd6554;

  localparam logic [CfgIdxW-1:0] CfgProcNoise = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMeasNoise = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInitEst = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgInitCov = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] process_noise;
    logic [DataW-1:0] measurement_noise;
    logic [DataW-1:0] initial_estimate;
    logic [DataW-1:0] initial_covariance;
  } skf_cfg_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic div_step;
    logic mul_corr;
    logic mul_cov;
    logic fin;
    logic out_load;
  } skf_cmd_t;

  typedef struct packed {
    logic skip;
  } skf_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/skf_cfg.sv @@
// Configuration register file of the scalar Kalman filter.
`default_nettype none

module skf_cfg
  import skf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  output skf_cfg_t           cfg_o
);

  skf_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_noise <= ProcNoiseRst;
      cfg_q.measurement_noise <= MeasNoiseRst;
      cfg_q.initial_estimate <= InitEstRst;
      cfg_q.initial_covariance <= InitCovRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgProcNoise: cfg_q.process_noise <= cfg_data_i;
        CfgMeasNoise: cfg_q.measurement_noise <= cfg_data_i;
        CfgInitEst: cfg_q.initial_estimate <= cfg_data_i;
        CfgInitCov: cfg_q.initial_covariance <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/skf_ctrl.sv @@
// Sequencing state machine of the scalar Kalman filter.
`default_nettype none

module skf_ctrl
  import skf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  skf_status_t status_i,
  output skf_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_FIN,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic             out_valid_q;
  logic             out_load;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load_in = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep = (state_q == S_PREP);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.mul_corr = (state_q == S_MUL1);
    cmd_o.mul_cov = (state_q == S_MUL2);
    cmd_o.fin = (state_q == S_FIN);
    cmd_o.out_load = out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_q <= '0;
          state_q <= status_i.skip ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_q <= S_MUL1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_FIN;
        S_FIN: state_q <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/skf_dp.sv @@
// Datapath of the scalar Kalman filter: state, divider, shared multiplier, result register.
`default_nettype none

module skf_dp
  import skf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  skf_cfg_t                cfg_i,
  input  skf_cmd_t                cmd_i,
  output skf_status_t             status_o,
  input  logic signed [DataW-1:0] measurement_i,
  input  logic                    start_of_run_i,
  output logic signed [DataW-1:0] estimate_o,
  output logic [GainW-1:0]        gain_o,
  output logic                    fault_o
);

  logic signed [DataW-1:0] x_q;
  logic [DataW-1:0]        p_q;
  logic                    fault_q;
  logic signed [DataW-1:0] z_q;
  logic                    start_q;
  logic [GainW-1:0]        k_q;
  logic [DataW+1:0]        rem_q;
  logic [DataW:0]          den_q;
  logic signed [50:0]      prod_q;
  logic signed [DataW-1:0] est_q;
  logic [GainW-1:0]        gain_q;
  logic                    fault_out_q;

  logic [DataW-1:0]        base_p;
  logic                    faulted;
  logic [DataW:0]          psum;
  logic [DataW-1:0]        psat;
  logic [DataW:0]          den_sum;
  logic                    zero_den;
  logic                    rem_ge;
  logic [DataW+1:0]        rem_n;
  logic signed [17:0]      mul_a;
  logic signed [DataW:0]   mul_b;
  logic signed [50:0]      mul_p;
  logic signed [DataW:0]   diff;
  logic signed [50:0]      rnd;
  logic signed [34:0]      corr;
  logic signed [35:0]      nx;
  logic signed [DataW-1:0] x_sat;

  // Covariance prediction, saturating, and the gain denominator.
  assign base_p = start_q ? cfg_i.initial_covariance : p_q;
  assign faulted = start_q ? 1'b0 : fault_q;
  assign psum = {1'b0, base_p} + {1'b0, cfg_i.process_noise};
  assign psat = psum[DataW] ? '1 : psum[DataW-1:0];
  assign den_sum = {1'b0, psat} + {1'b0, cfg_i.measurement_noise};
  assign zero_den = (den_sum == '0);
  assign status_o.skip = faulted || zero_den;

  // One restoring division step per cycle, one gain bit each.
  assign rem_ge = (rem_q >= {1'b0, den_q});
  assign rem_n = rem_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  // Shared multiplier: correction k*(z-x), then (1-k)*p.
  assign diff = $signed({z_q[DataW-1], z_q}) - $signed({x_q[DataW-1], x_q});
  assign mul_a = cmd_i.mul_corr ? $signed({1'b0, k_q}) : $signed({1'b0, GainOne - k_q});
  assign mul_b = cmd_i.mul_corr ? diff : $signed({1'b0, p_q});
  assign mul_p = mul_a * mul_b;

  // Round the correction to nearest, ties upward, and saturate the new estimate.
  assign rnd = prod_q + 51'sd32768;
  assign corr = rnd[50:16];
  assign nx = $signed({{4{x_q[DataW-1]}}, x_q}) + $signed({corr[34], corr});

  always_comb begin
    if (nx[35:31] == {5{nx[35]}}) begin
      x_sat = nx[DataW-1:0];
    end else if (nx[35]) begin
      x_sat = 32'sh8000_0000;
    end else begin
      x_sat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= InitEstRst;
      p_q <= InitCovRst;
      fault_q <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        if (start_q) begin
          x_q <= cfg_i.initial_estimate;
        end
        if (!faulted) begin
          p_q <= psat;
          fault_q <= zero_den;
        end
      end
      if (cmd_i.mul_cov) begin
        x_q <= x_sat;
      end
      if (cmd_i.fin) begin
        p_q <= prod_q[47:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      z_q <= measurement_i;
      start_q <= start_of_run_i;
    end
    if (cmd_i.prep) begin
      k_q <= '0;
      rem_q <= {2'b00, psat};
      den_q <= den_sum;
    end
    if (cmd_i.div_step) begin
      k_q <= {k_q[GainW-2:0], rem_ge};
      rem_q <= {rem_n[DataW:0], 1'b0};
    end
    if (cmd_i.mul_corr || cmd_i.mul_cov) begin
      prod_q <= mul_p;
    end
    if (cmd_i.out_load) begin
      est_q <= x_q;
      gain_q <= k_q;
      fault_out_q <= fault_q;
    end
  end

  assign estimate_o = est_q;
  assign gain_o = gain_q;
  assign fault_o = fault_out_q;

endmodule

`default_nettype wire

@@ hw/rtl/scalar_kalman_filter.sv @@
// Top level of the one-dimensional Kalman filter over a measurement stream.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_stall    measurement, start_of_run
//   out       output     out_valid/out_stall  estimate, gain, fault
//   cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item passes from its transfer to the output register through a prepare
// step, the 17-step gain divider, two products on the shared multiplier, the
// covariance write and the output load. The next item is taken in the cycle
// after the output load; an item that faults skips from prepare to the load.
// After reset the estimate and covariance hold the reset values of the
// initial registers; there is no clearing pass. A stalled output holds the
// finished item; the next item computes up to its final write and then waits.
`default_nettype none

module scalar_kalman_filter
  import skf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] measurement_i,
  input  logic                    start_of_run_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] estimate_o,
  output logic [GainW-1:0]        gain_o,
  output logic                    fault_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i
);

  skf_cfg_t    cfg;
  skf_cmd_t    cmd;
  skf_status_t status;

  skf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  skf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .measurement_i  (measurement_i),
    .start_of_run_i (start_of_run_i),
    .estimate_o     (estimate_o),
    .gain_o         (gain_o),
    .fault_o        (fault_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/skf_checker.sv @@
// Port-level assertion checker for the scalar Kalman filter, bound to the top level.
`default_nettype none
`include "scalar_kalman_filter_defines.svh"

module skf_checker
  import skf_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [DataW-1:0] estimate_o,
  input logic [GainW-1:0]        gain_o,
  input logic                    fault_o
);

  `SKF_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o && $stable(estimate_o))
  `SKF_ASSERT_NOW(a_fault_gain_zero, out_valid_o && fault_o, gain_o == '0)
  `SKF_ASSERT_NOW(a_gain_range, out_valid_o, gain_o <= GainOne)
  `SKF_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .estimate_o  (estimate_o),
  .gain_o      (gain_o),
  .fault_o     (fault_o)
);

`default_nettype wire

@@ tb/sv/tb_scalar_kalman_filter.sv @@
// Self-checking testbench for the scalar Kalman filter: directed table, random runs, predictor.
module tb_scalar_kalman_filter;
  import skf_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] estimate;
    logic [GainW-1:0]        gain;
    logic                    fault;
  } kf_result_t;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [DataW-1:0]   value;
    logic               start;
    logic               typed;
    kf_result_t         want;
  } row_t;

  localparam logic [DataW-1:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] IntMin = 32'h8000_0000;
  localparam logic [DataW-1:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] OneQ16 = 32'h0001_0000;
  localparam longint EstMax = 64'sd2147483647;
  localparam longint EstMin = -64'sd2147483648;
  localparam int PlanLen = 33;
  localparam int Phases = 12;
  localparam int ItemsPerPhase = 75;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 40;
  localparam int CycleLimit = 1000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [DataW-1:0] measurement_i;
  logic                    start_of_run_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [DataW-1:0] estimate_o;
  logic [GainW-1:0]        gain_o;
  logic                    fault_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [DataW-1:0]        cfg_data_i;

  skf_cfg_t                noise_cfg;
  logic signed [DataW-1:0] track_est;
  logic [DataW-1:0]        track_cov;
  logic                    track_fault;
  kf_result_t              awaited_estimates[$];
  int                      mismatch_count = 0;
  int                      cycle_count = 0;
  bit                      quiet = 1'b0;
  bit                      hold_req = 1'b0;

  row_t plan [PlanLen] = '{
    '{RowItem, CfgProcNoise, 32'd327680, 1'b0, 1'b1, '{32'd327680, 17'd43690, 1'b0}},
    '{RowItem, CfgProcNoise, IntMax, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, IntMin, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, 32'd0, 1'b1, 1'b0, '0},
    '{RowCfg, CfgProcNoise, 32'd0, 1'b0, 1'b0, '0},
    '{RowCfg, CfgMeasNoise, 32'd0, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitCov, 32'd0, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitEst, IntMin, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, 32'd123, 1'b1, 1'b1, '{IntMin, 17'd0, 1'b1}},
    '{RowItem, CfgProcNoise, IntMax, 1'b0, 1'b1, '{IntMin, 17'd0, 1'b1}},
    '{RowCfg, CfgInitCov, 32'd1, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, IntMax, 1'b1, 1'b1, '{IntMax, GainOne, 1'b0}},
    '{RowItem, CfgProcNoise, IntMin, 1'b0, 1'b1, '{IntMax, 17'd0, 1'b1}},
    '{RowItem, CfgProcNoise, 32'd0, 1'b0, 1'b1, '{IntMax, 17'd0, 1'b1}},
    '{RowCfg, CfgProcNoise, AllOnes, 1'b0, 1'b0, '0},
    '{RowCfg, CfgMeasNoise, AllOnes, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitCov, AllOnes, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitEst, IntMax, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, IntMin, 1'b1, 1'b0, '0},
    '{RowItem, CfgProcNoise, 32'd0, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, IntMax, 1'b0, 1'b0, '0},
    '{RowCfg, CfgProcNoise, 32'd0, 1'b0, 1'b0, '0},
    '{RowCfg, CfgMeasNoise, 32'd1, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitCov, 32'd0, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitEst, OneQ16, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, IntMax, 1'b1, 1'b1, '{OneQ16, 17'd0, 1'b0}},
    '{RowItem, CfgProcNoise, IntMin, 1'b0, 1'b1, '{OneQ16, 17'd0, 1'b0}},
    '{RowCfg, CfgProcNoise, ProcNoiseRst, 1'b0, 1'b0, '0},
    '{RowCfg, CfgMeasNoise, MeasNoiseRst, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitEst, InitEstRst, 1'b0, 1'b0, '0},
    '{RowCfg, CfgInitCov, InitCovRst, 1'b0, 1'b0, '0},
    '{RowItem, CfgProcNoise, AllOnes, 1'b1, 1'b0, '0},
    '{RowItem, CfgProcNoise, 32'h7FFF_0000, 1'b0, 1'b0, '0}
  };

  scalar_kalman_filter dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic kf_result_t kalman_update(logic signed [DataW-1:0] z, logic start);
    kf_result_t res;
    logic [32:0] p_sum;
    logic [33:0] denom;
    logic [63:0] quot;
    logic [63:0] cov_next;
    longint gain_l;
    longint next_est;
    gain_l = 0;
    if (start) begin
      track_est = noise_cfg.initial_estimate;
      track_cov = noise_cfg.initial_covariance;
      track_fault = 1'b0;
    end
    if (!track_fault) begin
      p_sum = {1'b0, track_cov} + {1'b0, noise_cfg.process_noise};
      if (p_sum[32]) begin
        p_sum = {1'b0, AllOnes};
      end
      track_cov = p_sum[DataW-1:0];
      denom = {1'b0, p_sum} + {2'b00, noise_cfg.measurement_noise};
      if (denom == '0) begin
        track_fault = 1'b1;
      end else begin
        quot = {15'd0, p_sum, 16'd0} / {30'd0, denom};
        gain_l = longint'(quot);
        next_est = longint'(track_est)
                 + ((gain_l * (longint'(z) - longint'(track_est)) + 64'sd32768) >>> 16);
        if (next_est > EstMax) begin
          next_est = EstMax;
        end
        if (next_est < EstMin) begin
          next_est = EstMin;
        end
        track_est = next_est[DataW-1:0];
        cov_next = ((64'd65536 - quot) * {31'd0, p_sum}) >> 16;
        track_cov = cov_next[DataW-1:0];
      end
    end
    res.estimate = track_est;
    res.gain = track_fault ? '0 : gain_l[GainW-1:0];
    res.fault = track_fault;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DataW-1:0] pick_u32();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return AllOnes;
      2, 3: return $urandom_range(0, 16);
      4, 5, 6: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (awaited_estimates.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    wait_drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      CfgProcNoise: noise_cfg.process_noise = data;
      CfgMeasNoise: noise_cfg.measurement_noise = data;
      CfgInitEst: noise_cfg.initial_estimate = data;
      CfgInitCov: noise_cfg.initial_covariance = data;
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(logic start, logic [DataW-1:0] z, logic typed, kf_result_t want);
    int gap;
    kf_result_t got;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    measurement_i <= z;
    start_of_run_i <= start;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    got = kalman_update(z, start);
    awaited_estimates.push_back(typed ? want : got);
  endtask

  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        repeat (HoldCycles) @(negedge clk_i) out_stall_i <= 1'b1;
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk_i) out_stall_i <= 1'b0;
        n = pick_gap();
        repeat (n) @(negedge clk_i) out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    kf_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_estimates.size() == 0) begin
        $display("%0t: transfer with no expectation waiting, estimate %0d",
                 $time, estimate_o);
        mismatch_count++;
      end else begin
        want = awaited_estimates.pop_front();
        if (estimate_o !== want.estimate) begin
          $display("%0t: estimate expected %0d, got %0d",
                   $time, $signed(want.estimate), estimate_o);
          mismatch_count++;
        end
        if (gain_o !== want.gain) begin
          $display("%0t: gain expected %0d, got %0d", $time, want.gain, gain_o);
          mismatch_count++;
        end
        if (fault_o !== want.fault) begin
          $display("%0t: fault expected %0d, got %0d", $time, want.fault, fault_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic start;
    logic signed [DataW-1:0] z;
    int noise;
    int pick;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    measurement_i = '0;
    start_of_run_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgProcNoise;
    cfg_data_i = '0;
    noise_cfg = '{ProcNoiseRst, MeasNoiseRst, InitEstRst, InitCovRst};
    track_est = InitEstRst;
    track_cov = InitCovRst;
    track_fault = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    for (int i = 0; i < PlanLen; i++) begin
      if (plan[i].kind == RowCfg) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_item(plan[i].start, plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin
          write_reg(CfgProcNoise, AllOnes);
          write_reg(CfgMeasNoise, AllOnes);
          write_reg(CfgInitEst, IntMax);
          write_reg(CfgInitCov, AllOnes);
        end
        1: begin
          write_reg(CfgProcNoise, '0);
          write_reg(CfgMeasNoise, '0);
          write_reg(CfgInitEst, IntMin);
          write_reg(CfgInitCov, '0);
        end
        2: begin
          write_reg(CfgProcNoise, '0);
          write_reg(CfgMeasNoise, '0);
          write_reg(CfgInitEst, $urandom);
          write_reg(CfgInitCov, $urandom_range(1, 1 << 20));
        end
        default: begin
          write_reg(CfgProcNoise, pick_u32());
          write_reg(CfgMeasNoise, pick_u32());
          write_reg(CfgInitEst, $urandom);
          write_reg(CfgInitCov, pick_u32());
        end
      endcase
      quiet = (ph == 5);
      if (ph == 3) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < ItemsPerPhase; i++) begin
        start = (i == 0) || ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 3))
            0: z = IntMax;
            1: z = IntMin;
            2: z = '0;
            default: z = AllOnes;
          endcase
        end else if (pick < 3) begin
          z = $urandom;
        end else begin
          noise = $urandom_range(0, 1 << 20);
          z = track_est + noise - (1 << 19);
        end
        send_item(start, z, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    wait_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/skf_pkg.sv
hw/rtl/skf_cfg.sv
hw/rtl/skf_ctrl.sv
hw/rtl/skf_dp.sv
hw/rtl/scalar_kalman_filter.sv
hw/rtl/skf_checker.sv
tb/sv/tb_scalar_kalman_filter.sv
